>>> rtl/core/vtp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vtp_pkg;

   // Default pool size.
   localparam int NUM_TIMERS_DEF = 8;

   localparam int FUNC_W  = 3;
   localparam int INDEX_W = 3;
   localparam int TIME_W  = 32;

   // Operation codes carried in the func field.
   localparam logic [FUNC_W-1:0] OP_TICK  = 3'd0;
   localparam logic [FUNC_W-1:0] OP_ALLOC = 3'd1;
   localparam logic [FUNC_W-1:0] OP_FREE  = 3'd2;
   localparam logic [FUNC_W-1:0] OP_SET   = 3'd3;
   localparam logic [FUNC_W-1:0] OP_QUERY = 3'd4;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] timer_index;
      logic [TIME_W-1:0]  duration_ms;
   } vtp_req_type;

   typedef struct packed {
      logic               alloc_ok;
      logic [INDEX_W-1:0] alloc_index;
      logic               expired;
      logic [TIME_W-1:0]  time_left;
   } vtp_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_INC,
      ST_SCAN,
      ST_ALLOC,
      ST_FREE,
      ST_SET,
      ST_QUERY_RD,
      ST_QUERY_SUB
   } vtp_state_type;

endpackage

`default_nettype wire

>>> rtl/core/virtual_timer_pool.sv
`timescale 1ns / 1ps
`default_nettype none

// Pool of one-shot millisecond timers with a private 32-bit millisecond counter.
// A command transaction is taken on the req_data port at a rising edge where
// start is high and busy is low. The func field selects tick, alloc, free, set
// or query; any other code produces an all-zero result and changes nothing.
// Every command produces exactly one result transaction on rsp_data, flagged
// by a single-cycle rsp_valid strobe in the same cycle that busy drops, or
// right after the accepting edge for an unknown code, which never raises busy.
// The receiver cannot stall, so results are never held or queued.
// All time arithmetic goes through one shared 32-bit adder/subtractor under a
// small sequencer, and deadlines live in a single-port memory with a
// registered read. While busy, a tick does one increment, then one memory
// read per timer with each compare trailing its read; alloc tests one flag per
// cycle until a free timer is found; query reads, then subtracts; free and set
// each run in a single state; unknown codes never raise busy. A tick is the
// longest command.
// A synchronous reset returns the sequencer to idle, clears the counter and
// marks every timer expired, unused and stopped. The deadline memory is not
// cleared: an entry is only ever looked at after a set has written it.
module virtual_timer_pool #(
   parameter int NUM_TIMERS = vtp_pkg::NUM_TIMERS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire vtp_pkg::vtp_req_type req_data,
   output logic                     rsp_valid,
   output vtp_pkg::vtp_rsp_type     rsp_data
);

   import vtp_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(NUM_TIMERS);

   vtp_state_type state_ff, state_in;

   vtp_req_type req_ff, req_in;
   vtp_rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [TIME_W-1:0] now_ff, now_in;

   logic [NUM_TIMERS-1:0] running_ff, running_in;
   logic [NUM_TIMERS-1:0] in_use_ff, in_use_in;
   logic [NUM_TIMERS-1:0] expired_ff, expired_in;

   // Scan counter shared by tick and alloc, plus the one-stage compare
   // pipeline that trails the memory read during a tick.
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   logic             pvld_ff, pvld_in;

   // Deadline memory: one port, written or read at mem_addr each cycle.
   logic [TIME_W-1:0] deadline_mem [NUM_TIMERS];
   logic [TIME_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]  mem_addr;
   logic              mem_we;

   // The one shared adder. Subtraction is a + ~b + 1.
   logic [TIME_W-1:0] add_a, add_b, add_sum;
   logic              add_cin;

   logic [IDX_W-1:0] req_idx;
   logic             req_idx_ok;
   logic [IDX_W-1:0] scan_idx;

   assign add_sum    = TIME_W'(add_a + add_b + TIME_W'(add_cin));
   assign req_idx    = IDX_W'(req_ff.timer_index);
   assign req_idx_ok = 32'(req_ff.timer_index) < NUM_TIMERS;
   assign scan_idx   = scan_ff[IDX_W-1:0];

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         deadline_mem[mem_addr] <= add_sum;
      end
      rd_data_ff <= deadline_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         now_ff       <= '0;
         running_ff   <= '0;
         in_use_ff    <= '0;
         expired_ff   <= '1;
         scan_ff      <= '0;
         pvld_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         now_ff       <= now_in;
         running_ff   <= running_in;
         in_use_ff    <= in_use_in;
         expired_ff   <= expired_in;
         scan_ff      <= scan_in;
         pvld_ff      <= pvld_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      pidx_ff <= pidx_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      now_in       = now_ff;
      running_in   = running_ff;
      in_use_in    = in_use_ff;
      expired_in   = expired_ff;
      scan_in      = scan_ff;
      pidx_in      = pidx_ff;
      pvld_in      = 1'b0;
      mem_addr     = req_idx;
      mem_we       = 1'b0;
      add_a        = now_ff;
      add_b        = '0;
      add_cin      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in  = req_data;
               rsp_in  = '0;
               scan_in = '0;
               case (req_data.func)
                  OP_TICK:  state_in = ST_TICK_INC;
                  OP_ALLOC: state_in = ST_ALLOC;
                  OP_FREE:  state_in = ST_FREE;
                  OP_SET:   state_in = ST_SET;
                  OP_QUERY: state_in = ST_QUERY_RD;
                  default: begin
                     // Unknown code: answer with an all-zero result at once.
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ST_TICK_INC: begin
            add_cin  = 1'b1;
            now_in   = add_sum;
            state_in = ST_SCAN;
         end

         ST_SCAN: begin
            // Compare stage: the deadline read last cycle against the new count.
            add_a   = rd_data_ff;
            add_b   = ~now_ff;
            add_cin = 1'b1;
            if (pvld_ff && running_ff[pidx_ff] && (add_sum == '0)) begin
               running_in[pidx_ff] = 1'b0;
               expired_in[pidx_ff] = 1'b1;
            end
            // Read stage: fetch the next timer's deadline.
            if (scan_ff != SCAN_END) begin
               mem_addr = scan_idx;
               pidx_in  = scan_idx;
               pvld_in  = 1'b1;
               scan_in  = scan_ff + 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_ALLOC: begin
            if (scan_ff == SCAN_END) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (!in_use_ff[scan_idx]) begin
               in_use_in[scan_idx] = 1'b1;
               rsp_in.alloc_ok     = 1'b1;
               rsp_in.alloc_index  = INDEX_W'(scan_ff);
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         ST_FREE: begin
            if (req_idx_ok) begin
               in_use_in[req_idx]  = 1'b0;
               running_in[req_idx] = 1'b0;
               expired_in[req_idx] = 1'b1;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         ST_SET: begin
            add_b = req_ff.duration_ms;
            if (req_idx_ok) begin
               if (req_ff.duration_ms == '0) begin
                  // A zero duration only forces expiry; running is left alone.
                  expired_in[req_idx] = 1'b1;
               end else begin
                  mem_we              = 1'b1;
                  expired_in[req_idx] = 1'b0;
                  running_in[req_idx] = 1'b1;
               end
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         ST_QUERY_RD: begin
            state_in = ST_QUERY_SUB;
         end

         ST_QUERY_SUB: begin
            add_a   = rd_data_ff;
            add_b   = ~now_ff;
            add_cin = 1'b1;
            if (!req_idx_ok) begin
               rsp_in.expired = 1'b1;
            end else begin
               rsp_in.expired = expired_ff[req_idx];
               if (in_use_ff[req_idx] && !expired_ff[req_idx]) begin
                  rsp_in.time_left = add_sum;
               end
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/vtp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module vtp_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 start,
   input wire logic                 busy,
   input wire vtp_pkg::vtp_req_type req_data,
   input wire logic                 rsp_valid,
   input wire vtp_pkg::vtp_rsp_type rsp_data
);

   import vtp_pkg::*;

   // An accepted command with a known code raises busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.func <= OP_QUERY) |=> busy)
      else $error("accepted transaction did not raise busy");

   // A result is delivered only while the block is idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // Finishing a command always delivers its result in the first idle cycle.
   a_rsp_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("command finished without a result strobe");

   // A failed or non-alloc result reports index zero.
   a_alloc_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.alloc_ok |-> rsp_data.alloc_index == '0)
      else $error("alloc index set without alloc_ok");

   // Time left is only reported for a timer that has not expired.
   a_left_live: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.time_left != '0) |-> !rsp_data.expired)
      else $error("time left reported for an expired timer");

endmodule

bind virtual_timer_pool vtp_checker u_vtp_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire
